// ----- src/trap_pkg.sv -----
// Shared constants, command and status types for the trapezoid integrator.
package trap_pkg;

  // Number format and problem size
  localparam int FRAC_BITS    = 24;
  localparam int MAX_SEGMENTS = 65536;

  // Port field widths
  localparam int IN_W     = 32;
  localparam int SEG_IN_W = 17;
  localparam int AREA_W   = 39;

  // Internal widths
  localparam int SUM_W   = 48;
  localparam int CNT_W   = $clog2(MAX_SEGMENTS + 1);
  localparam int XW      = $clog2(MAX_SEGMENTS) + IN_W + 2;
  localparam int PROD_W  = 2 * IN_W;
  localparam int Q_W     = FRAC_BITS + 3;
  localparam int DEN_W   = SUM_W + 1;
  localparam int DCNT_W  = $clog2(Q_W);
  localparam int FULL_W  = IN_W + SUM_W;

  localparam logic [SUM_W-1:0] SUM_MAX = '1;

  // Which abscissa the shared f(x) unit works on
  typedef enum logic [1:0] {
    PT_START,
    PT_END,
    PT_INNER
  } pt_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic sq;
    logic dinit;
    logic dstep;
    logic acc;
    logic mul_lo;
    logic mul_hi;
    logic finish;
    pt_t  pt;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic div_last;
    logic more;
  } stat_t;

endpackage

// ----- src/trap_dp.sv -----
// Datapath: shared multiplier, restoring divider, saturating sum and area scaling.
module trap_dp (
  input  logic                           clk,
  input  logic signed [trap_pkg::IN_W-1:0] x_start,
  input  logic signed [trap_pkg::IN_W-1:0] x_end,
  input  logic [trap_pkg::IN_W-1:0]      step_width,
  input  logic [trap_pkg::SEG_IN_W-1:0]  segments,
  input  trap_pkg::cmd_t                 cmd,
  output trap_pkg::stat_t                stat,
  output logic [trap_pkg::AREA_W-1:0]    area,
  output logic                           saturated
);
  import trap_pkg::*;

  localparam logic [DEN_W-1:0] REM_INIT = DEN_W'(1) << (FRAC_BITS - 1);
  localparam logic [DEN_W-1:0] ONE_FX   = DEN_W'(1) << FRAC_BITS;

  // Request registers and loop state
  logic signed [IN_W-1:0] xs_q;
  logic signed [IN_W-1:0] xe_q;
  logic [IN_W-1:0]        h_q;
  logic [CNT_W-1:0]       n_q;
  logic [CNT_W-1:0]       idx_q;
  logic signed [XW-1:0]   cur_x;
  logic [SUM_W-1:0]       sum_q;
  logic                   sat_q;

  // Multiplier and divider registers
  logic [PROD_W-1:0] prod_q;
  logic [PROD_W-1:0] p0_q;
  logic              big_q;
  logic [DEN_W-1:0]  den_q;
  logic [DEN_W-1:0]  rem_q;
  logic [Q_W-1:0]    quo_q;
  logic [DCNT_W-1:0] dcnt_q;

  // Combinational signals
  logic [CNT_W-1:0]     n_in;
  logic signed [XW-1:0] x_sel;
  logic [XW-1:0]        ax;
  logic                 big;
  logic [IN_W-1:0]      mul_a;
  logic [IN_W-1:0]      mul_b;
  logic [PROD_W-1:0]    sq_raw;
  logic [SUM_W-1:0]     sq;
  logic [DEN_W:0]       trial;
  logic [DEN_W:0]       diff;
  logic                 ge;
  logic [Q_W:0]         addend;
  logic [SUM_W:0]       acc_sum;
  logic [FULL_W-1:0]    full;
  logic                 area_ovf;
  logic signed [XW-1:0] h_ext;
  logic signed [XW-1:0] hin_ext;

  // Segment count clamp
  assign n_in = (32'(segments) > 32'(MAX_SEGMENTS)) ? CNT_W'(MAX_SEGMENTS) : CNT_W'(segments);

  assign h_ext   = {{(XW - IN_W){1'b0}}, h_q};
  assign hin_ext = {{(XW - IN_W){1'b0}}, step_width};

  // Abscissa select and magnitude
  always_comb begin
    case (cmd.pt)
      PT_START: x_sel = XW'(xs_q);
      PT_END:   x_sel = XW'(xe_q);
      default:  x_sel = cur_x;
    endcase
  end

  assign ax  = x_sel[XW-1] ? XW'(-x_sel) : XW'(x_sel);
  assign big = |ax[XW-1:IN_W];

  // Shared 32x32 multiplier operands
  always_comb begin
    if (cmd.mul_lo) begin
      mul_a = h_q;
      mul_b = sum_q[IN_W-1:0];
    end else if (cmd.mul_hi) begin
      mul_a = h_q;
      mul_b = IN_W'(sum_q[SUM_W-1:IN_W]);
    end else begin
      mul_a = ax[IN_W-1:0];
      mul_b = ax[IN_W-1:0];
    end
  end

  // Square scaled back to Q.FRAC, saturating
  assign sq_raw = prod_q >> FRAC_BITS;
  assign sq     = (big_q || (sq_raw > PROD_W'(SUM_MAX))) ? SUM_MAX : sq_raw[SUM_W-1:0];

  // One restoring division step
  assign trial = {rem_q, 1'b0};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = (trial >= {1'b0, den_q});

  // Interior points count twice
  assign addend  = (cmd.pt == PT_INNER) ? {quo_q, 1'b0} : {1'b0, quo_q};
  assign acc_sum = {1'b0, sum_q} + (SUM_W + 1)'(addend);

  // Exact h * sum from the two partial products
  assign full     = FULL_W'(p0_q) + (FULL_W'(prod_q) << IN_W);
  assign area_ovf = |full[FULL_W-1:FRAC_BITS+1+AREA_W];

  assign stat.div_last = (dcnt_q == '0);
  assign stat.more     = (idx_q < n_q);

  // Request capture and loop variables
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      xs_q  <= x_start;
      xe_q  <= x_end;
      h_q   <= step_width;
      n_q   <= n_in;
      idx_q <= CNT_W'(1);
      cur_x <= XW'(x_start) + hin_ext;
      sum_q <= '0;
      sat_q <= 1'b0;
    end else if (cmd.acc) begin
      if (acc_sum[SUM_W]) begin
        sum_q <= SUM_MAX;
        sat_q <= 1'b1;
      end else begin
        sum_q <= acc_sum[SUM_W-1:0];
      end
      if (cmd.pt == PT_INNER) begin
        cur_x <= cur_x + h_ext;
        idx_q <= idx_q + CNT_W'(1);
      end
    end
  end

  // Multiplier output register
  always_ff @(posedge clk) begin
    if (cmd.sq || cmd.mul_lo || cmd.mul_hi) begin
      prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
    end
    if (cmd.sq) begin
      big_q <= big;
    end
    if (cmd.mul_hi) begin
      p0_q <= prod_q;
    end
  end

  // Divider: 4.0 in Q.FRAC over (1 + x^2), one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (cmd.dinit) begin
      den_q  <= ONE_FX + DEN_W'(sq);
      rem_q  <= REM_INIT;
      quo_q  <= '0;
      dcnt_q <= DCNT_W'(Q_W - 1);
    end else if (cmd.dstep) begin
      rem_q  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo_q  <= {quo_q[Q_W-2:0], ge};
      dcnt_q <= dcnt_q - DCNT_W'(1);
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      area      <= area_ovf ? {AREA_W{1'b1}} : full[FRAC_BITS+AREA_W:FRAC_BITS+1];
      saturated <= sat_q | area_ovf;
    end
  end

endmodule

// ----- src/trap_ctrl.sv -----
// Controller: sequences endpoint and interior evaluations, then the area scaling.
module trap_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  input  trap_pkg::stat_t stat,
  output trap_pkg::cmd_t  cmd
);
  import trap_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SQ,
    S_DINIT,
    S_DIV,
    S_ACC,
    S_CHECK,
    S_MUL_LO,
    S_MUL_HI,
    S_FIN
  } state_t;

  state_t state;
  pt_t    pt_q;
  logic   out_free;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  // Commands decoded from state
  always_comb begin
    cmd        = '0;
    cmd.pt     = pt_q;
    case (state)
      S_IDLE:   cmd.load   = in_valid;
      S_SQ:     cmd.sq     = 1'b1;
      S_DINIT:  cmd.dinit  = 1'b1;
      S_DIV:    cmd.dstep  = 1'b1;
      S_ACC:    cmd.acc    = 1'b1;
      S_MUL_LO: cmd.mul_lo = 1'b1;
      S_MUL_HI: cmd.mul_hi = 1'b1;
      S_FIN:    cmd.finish = out_free;
      default:  cmd        = '0;
    endcase
  end

  // State and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      pt_q      <= PT_START;
      out_valid <= 1'b0;
    end else begin
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            pt_q  <= PT_START;
            state <= S_SQ;
          end
        end
        S_SQ:    state <= S_DINIT;
        S_DINIT: state <= S_DIV;
        S_DIV: begin
          if (stat.div_last) state <= S_ACC;
        end
        S_ACC: begin
          if (pt_q == PT_START) begin
            pt_q  <= PT_END;
            state <= S_SQ;
          end else begin
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (stat.more) begin
            pt_q  <= PT_INNER;
            state <= S_SQ;
          end else begin
            state <= S_MUL_LO;
          end
        end
        S_MUL_LO: state <= S_MUL_HI;
        S_MUL_HI: state <= S_FIN;
        S_FIN: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- src/trapezoid_integrate_recip_quadratic.sv -----
// Top level: trapezoidal rule integrator of 4/(1+x^2) in signed Q8.24.
//
//   channel  direction  handshake            payload
//   in       request    in_valid / in_stall  x_start, x_end, step_width, segments
//   out      result     out_valid/out_stall  area, saturated
//
// Each f(x) is one square on the shared 32x32 multiplier, one
// divisor set-up, 27 restoring division steps and one saturating add.
// A request evaluates both endpoints and the n-1 interior points for n >= 1
// segments, none for n = 0; a new request is taken once the previous result
// sits in the output register. Synchronous reset returns the controller to idle.
// A stalled result holds; the next request finishes only once it has left.
module trapezoid_integrate_recip_quadratic (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [trap_pkg::IN_W-1:0] x_start,
  input  logic signed [trap_pkg::IN_W-1:0] x_end,
  input  logic [trap_pkg::IN_W-1:0]        step_width,
  input  logic [trap_pkg::SEG_IN_W-1:0]    segments,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [trap_pkg::AREA_W-1:0]      area,
  output logic                             saturated
);
  import trap_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  trap_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  trap_dp u_dp (
    .clk        (clk),
    .x_start    (x_start),
    .x_end      (x_end),
    .step_width (step_width),
    .segments   (segments),
    .cmd        (cmd),
    .stat       (stat),
    .area       (area),
    .saturated  (saturated)
  );

endmodule
